### hdl/lwc_pkg.sv
package lwc_pkg;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam logic [3:0] CODE_TOP    = 4'h1;
    localparam logic [3:0] CODE_BOTTOM = 4'h2;
    localparam logic [3:0] CODE_RIGHT  = 4'h4;
    localparam logic [3:0] CODE_LEFT   = 4'h8;
    localparam logic [1:0] REG_X_MIN = 2'd0;
    localparam logic [1:0] REG_Y_MIN = 2'd1;
    localparam logic [1:0] REG_X_MAX = 2'd2;
    localparam logic [1:0] REG_Y_MAX = 2'd3;
    localparam int MAX_CLIPS = 4;

    typedef struct packed {
        logic load;
        logic setup;
        logic mul;
        logic div_start;
        logic update;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic both_in;
        logic reject;
        logic div_done;
    } t_status;
endpackage

### hdl/lwc_if.sv
interface lwc_seg_if #(parameter int W = 16);
    logic valid;
    logic ready;
    logic signed [W-1:0] start_x;
    logic signed [W-1:0] start_y;
    logic signed [W-1:0] end_x;
    logic signed [W-1:0] end_y;
    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lwc_res_if #(parameter int W = 16);
    logic valid;
    logic ready;
    logic accepted;
    logic signed [W-1:0] clipped_start_x;
    logic signed [W-1:0] clipped_start_y;
    logic signed [W-1:0] clipped_end_x;
    logic signed [W-1:0] clipped_end_y;
    modport source (output valid, accepted, clipped_start_x, clipped_start_y,
                    clipped_end_x, clipped_end_y, input ready);
    modport sink (input valid, accepted, clipped_start_x, clipped_start_y,
                  clipped_end_x, clipped_end_y, output ready);
endinterface

### hdl/lwc_datapath.sv
module lwc_datapath
    import lwc_pkg::*;
#(
    parameter int W = COORD_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    output t_status o_status,
    input  logic signed [W-1:0] i_x0, i_y0, i_x1, i_y1,
    input  logic signed [W-1:0] i_xmin, i_ymin, i_xmax, i_ymax,
    output logic o_accept,
    output logic signed [W-1:0] o_x0, o_y0, o_x1, o_y1
);
    localparam int DW = W + 1;
    localparam int PW = 2 * DW;
    localparam int CW = $clog2(PW + 1);

    logic signed [W-1:0] r_x0, r_y0, r_x1, r_y1;
    logic [3:0] r_c0, r_c1;
    logic signed [DW-1:0] r_delta, r_num, r_den;
    logic r_neg, r_sel1, r_horiz;
    logic signed [W-1:0] r_edge, r_base;
    logic [PW-1:0] r_prod;
    logic [DW-1:0] r_rem;
    logic [CW-1:0] r_cnt;
    logic r_busy;
    logic r_accept;
    logic signed [W-1:0] r_ox0, r_oy0, r_ox1, r_oy1;

    function automatic logic [3:0] region(input logic signed [W-1:0] x, y,
        input logic signed [W-1:0] xmin, ymin, xmax, ymax);
        logic [3:0] c;
        c = 4'h0;
        if (y > ymax) c = c | CODE_TOP;
        else if (y < ymin) c = c | CODE_BOTTOM;
        if (x > xmax) c = c | CODE_RIGHT;
        else if (x < xmin) c = c | CODE_LEFT;
        return c;
    endfunction

    function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
        return v[DW-1] ? DW'(-v) : DW'(v);
    endfunction

    logic [3:0] co;
    logic signed [DW-1:0] n_delta, n_num, n_den;
    logic signed [W-1:0] n_edge, n_base;
    logic n_horiz;
    logic [DW:0] rem_sh, rem_sub;
    logic signed [W-1:0] res_q, nx, ny;
    logic [3:0] nc;
    logic both_in;

    always_comb begin
        co = (r_c0 != 4'h0) ? r_c0 : r_c1;
        n_horiz = 1'b0;
        n_edge = i_xmin;
        if ((co & CODE_TOP) != 4'h0) begin
            n_horiz = 1'b1;
            n_edge = i_ymax;
        end else if ((co & CODE_BOTTOM) != 4'h0) begin
            n_horiz = 1'b1;
            n_edge = i_ymin;
        end else if ((co & CODE_RIGHT) != 4'h0) begin
            n_edge = i_xmax;
        end
        if (n_horiz) begin
            n_delta = DW'(r_x1) - DW'(r_x0);
            n_num = DW'(n_edge) - DW'(r_y0);
            n_den = DW'(r_y1) - DW'(r_y0);
            n_base = r_x0;
        end else begin
            n_delta = DW'(r_y1) - DW'(r_y0);
            n_num = DW'(n_edge) - DW'(r_x0);
            n_den = DW'(r_x1) - DW'(r_x0);
            n_base = r_y0;
        end
        rem_sh = {r_rem, r_prod[PW-1]};
        rem_sub = rem_sh - {1'b0, mag(r_den)};
        res_q = r_neg ? W'(r_base - W'(r_prod)) : W'(r_base + W'(r_prod));
        nx = r_horiz ? res_q : r_edge;
        ny = r_horiz ? r_edge : res_q;
        nc = region(nx, ny, i_xmin, i_ymin, i_xmax, i_ymax);
        both_in = (r_c0 == 4'h0) && (r_c1 == 4'h0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else if (i_cmd.div_start) begin
            r_busy <= 1'b1;
            r_cnt <= CW'(PW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) r_busy <= 1'b0;
        end
        if (i_cmd.load) begin
            r_x0 <= i_x0;
            r_y0 <= i_y0;
            r_x1 <= i_x1;
            r_y1 <= i_y1;
            r_c0 <= region(i_x0, i_y0, i_xmin, i_ymin, i_xmax, i_ymax);
            r_c1 <= region(i_x1, i_y1, i_xmin, i_ymin, i_xmax, i_ymax);
        end
        if (i_cmd.setup) begin
            r_delta <= n_delta;
            r_num <= n_num;
            r_den <= n_den;
            r_neg <= (n_delta[DW-1] ^ n_num[DW-1]) ^ n_den[DW-1];
            r_edge <= n_edge;
            r_base <= n_base;
            r_horiz <= n_horiz;
            r_sel1 <= (r_c0 == 4'h0);
        end
        if (i_cmd.mul) begin
            r_prod <= PW'(mag(r_delta)) * PW'(mag(r_num));
        end
        if (i_cmd.div_start) begin
            r_rem <= '0;
        end else if (r_busy) begin
            if (!rem_sub[DW]) begin
                r_rem <= rem_sub[DW-1:0];
                r_prod <= {r_prod[PW-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[DW-1:0];
                r_prod <= {r_prod[PW-2:0], 1'b0};
            end
        end
        if (i_cmd.update) begin
            if (!r_sel1) begin
                r_x0 <= nx;
                r_y0 <= ny;
                r_c0 <= nc;
            end else begin
                r_x1 <= nx;
                r_y1 <= ny;
                r_c1 <= nc;
            end
        end
        if (i_cmd.finish) begin
            r_accept <= both_in;
            r_ox0 <= both_in ? r_x0 : '0;
            r_oy0 <= both_in ? r_y0 : '0;
            r_ox1 <= both_in ? r_x1 : '0;
            r_oy1 <= both_in ? r_y1 : '0;
        end
    end

    assign o_status.both_in = both_in;
    assign o_status.reject = ((r_c0 & r_c1) != 4'h0) || (i_xmin > i_xmax)
        || (i_ymin > i_ymax);
    assign o_status.div_done = r_busy && (r_cnt == CW'(1));
    assign o_accept = r_accept;
    assign o_x0 = r_ox0;
    assign o_y0 = r_oy0;
    assign o_x1 = r_ox1;
    assign o_y1 = r_oy1;
endmodule

### hdl/lwc_ctrl.sv
module lwc_ctrl
    import lwc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_status i_status,
    output t_cmd o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TEST = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIVS = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_UPD  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;
    localparam logic [2:0] S_SET  = 3'd7;

    logic [2:0] r_state, n_state;
    logic [2:0] r_clips, n_clips;
    logic r_valid, n_valid;

    always_comb begin
        n_state = r_state;
        n_clips = r_clips;
        n_valid = r_valid;
        o_cmd = '0;
        if (r_valid && i_out_ready) n_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_clips = '0;
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                if (i_status.both_in || i_status.reject
                    || r_clips == 3'(MAX_CLIPS)) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.setup = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_DIVS;
            end
            S_DIVS: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: if (i_status.div_done) n_state = S_UPD;
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_clips = r_clips + 3'd1;
                n_state = S_TEST;
            end
            S_OUT: begin
                if (!r_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_clips <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clips <= n_clips;
            r_valid <= n_valid;
        end
    end

    a_finish_raises: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_valid)
        else $error("result not raised");
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_out_ready |=> r_valid)
        else $error("result dropped");
    a_clip_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clips <= 3'(MAX_CLIPS))
        else $error("too many clips");
endmodule

### hdl/line_window_clipper_core.sv
// Channel  Dir  Payload
// i_seg    in   start_x, start_y, end_x, end_y
// o_res    out  accepted, clipped_start_x/y, clipped_end_x/y
// cfg      in   i_cfg_we, i_cfg_index, i_cfg_data
// An item makes up to MAX_CLIPS edge clips, each through the bit-serial divider.
// Reset is synchronous and active low; the window returns to 0, 0, 639, 479.
// A held result does not block the next input transfer; only the finishing step
// waits until the output register is free.
module line_window_clipper_core
    import lwc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [COORD_WIDTH-1:0] i_cfg_data,
    lwc_seg_if.sink i_seg,
    lwc_res_if.source o_res
);
    logic signed [COORD_WIDTH-1:0] r_xmin, r_ymin, r_xmax, r_ymax;
    t_cmd cmd;
    t_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xmin <= '0;
            r_ymin <= '0;
            r_xmax <= COORD_WIDTH'(639);
            r_ymax <= COORD_WIDTH'(479);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_X_MIN: r_xmin <= i_cfg_data;
                REG_Y_MIN: r_ymin <= i_cfg_data;
                REG_X_MAX: r_xmax <= i_cfg_data;
                REG_Y_MAX: r_ymax <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lwc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_seg.valid), .o_in_ready(i_seg.ready),
        .o_out_valid(o_res.valid), .i_out_ready(o_res.ready),
        .i_status(status), .o_cmd(cmd)
    );

    lwc_datapath #(.W(COORD_WIDTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_x0(i_seg.start_x), .i_y0(i_seg.start_y),
        .i_x1(i_seg.end_x), .i_y1(i_seg.end_y),
        .i_xmin(r_xmin), .i_ymin(r_ymin), .i_xmax(r_xmax), .i_ymax(r_ymax),
        .o_accept(o_res.accepted),
        .o_x0(o_res.clipped_start_x), .o_y0(o_res.clipped_start_y),
        .o_x1(o_res.clipped_end_x), .o_y1(o_res.clipped_end_y)
    );
endmodule

### verif/tb_line_window_clipper_core.sv
`timescale 1ns / 1ps

module tb_line_window_clipper_core;
    import lwc_pkg::*;

    localparam int W = 16;
    localparam int CLIP_CYCLES = 3 + 4 * (4 + 2 * (W + 1));

    typedef logic signed [W-1:0] t_coord;

    typedef struct packed {
        t_coord sx;
        t_coord sy;
        t_coord ex;
        t_coord ey;
    } t_seg;

    typedef struct packed {
        logic   acc;
        t_coord sx;
        t_coord sy;
        t_coord ex;
        t_coord ey;
    } t_clip;

    typedef struct {
        t_seg  seg;
        logic  known;
        t_clip want;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index;
    logic [W-1:0] i_cfg_data;

    lwc_seg_if #(.W(W)) seg_ch ();
    lwc_res_if #(.W(W)) res_ch ();

    line_window_clipper_core #(.COORD_WIDTH(W)) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_seg(seg_ch.sink),
        .o_res(res_ch.source)
    );

    longint win_xmin, win_ymin, win_xmax, win_ymax;
    t_clip  clip_queue[$];
    int     errors = 0;
    int     segs_sent = 0;
    int     clips_seen = 0;
    int     rejects_seen = 0;
    bit     calm = 0;
    bit     hold_sink = 0;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("Timeout at %0t", $time);
        $display("tb_line_window_clipper_core NOT OK");
        $finish;
    end

    function automatic bit [3:0] region_of(longint x, longint y);
        bit [3:0] c;
        c = 4'h0;
        if (y > win_ymax) c |= CODE_TOP;
        else if (y < win_ymin) c |= CODE_BOTTOM;
        if (x > win_xmax) c |= CODE_RIGHT;
        else if (x < win_xmin) c |= CODE_LEFT;
        return c;
    endfunction

    // Truncating division toward zero, as the integer divide of the language does.
    function automatic longint edge_point(longint base, longint dlt, longint num, longint den);
        if (den == 0) return base;
        return base + (dlt * num) / den;
    endfunction

    function automatic t_clip clip_segment(t_seg s);
        longint x0, y0, x1, y1, x, y;
        bit [3:0] c0, c1, co;
        t_clip r;
        bit acc;
        acc = 0;
        x0 = s.sx; y0 = s.sy; x1 = s.ex; y1 = s.ey;
        if (win_xmin <= win_xmax && win_ymin <= win_ymax) begin
            c0 = region_of(x0, y0);
            c1 = region_of(x1, y1);
            for (int n = 0; n <= MAX_CLIPS; n++) begin
                if (c0 == 0 && c1 == 0) begin
                    acc = 1;
                    break;
                end
                if ((c0 & c1) != 0 || n == MAX_CLIPS) break;
                co = (c0 != 0) ? c0 : c1;
                if (co & CODE_TOP) begin
                    x = edge_point(x0, x1 - x0, win_ymax - y0, y1 - y0); y = win_ymax;
                end else if (co & CODE_BOTTOM) begin
                    x = edge_point(x0, x1 - x0, win_ymin - y0, y1 - y0); y = win_ymin;
                end else if (co & CODE_RIGHT) begin
                    y = edge_point(y0, y1 - y0, win_xmax - x0, x1 - x0); x = win_xmax;
                end else begin
                    y = edge_point(y0, y1 - y0, win_xmin - x0, x1 - x0); x = win_xmin;
                end
                if (c0 != 0) begin
                    x0 = x; y0 = y; c0 = region_of(x0, y0);
                end else begin
                    x1 = x; y1 = y; c1 = region_of(x1, y1);
                end
            end
        end
        r.acc = acc;
        r.sx = acc ? t_coord'(x0) : '0;
        r.sy = acc ? t_coord'(y0) : '0;
        r.ex = acc ? t_coord'(x1) : '0;
        r.ey = acc ? t_coord'(y1) : '0;
        return r;
    endfunction

    task automatic write_window(logic [1:0] idx, t_coord val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_X_MIN: win_xmin = val;
            REG_Y_MIN: win_ymin = val;
            REG_X_MAX: win_xmax = val;
            default:   win_ymax = val;
        endcase
    endtask

    task automatic set_window(t_coord xl, t_coord yl, t_coord xh, t_coord yh);
        seg_ch.valid <= 1'b0;
        while (clip_queue.size() != 0) @(posedge i_clk);
        repeat (CLIP_CYCLES + 10) @(posedge i_clk);
        write_window(REG_X_MIN, xl);
        write_window(REG_Y_MIN, yl);
        write_window(REG_X_MAX, xh);
        write_window(REG_Y_MAX, yh);
    endtask

    task automatic send_segment(t_seg s, bit known, t_clip want);
        t_clip pred;
        if (!calm && $urandom_range(0, 3) == 0) begin
            seg_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        pred = clip_segment(s);
        if (known && pred != want) begin
            $display("%0t: table row disagrees with prediction: exp %h got %h",
                     $time, want, pred);
            errors++;
        end
        seg_ch.valid   <= 1'b1;
        seg_ch.start_x <= s.sx;
        seg_ch.start_y <= s.sy;
        seg_ch.end_x   <= s.ex;
        seg_ch.end_y   <= s.ey;
        do @(posedge i_clk); while (!seg_ch.ready);
        clip_queue.push_back(known ? want : pred);
        segs_sent++;
    endtask

    function automatic t_coord rand_coord();
        case ($urandom_range(0, 3))
            0: return t_coord'($urandom);
            1: return t_coord'($urandom_range(0, 700)) - 30;
            2: return t_coord'($urandom_range(0, 2000)) - 1000;
            default: return t_coord'($urandom_range(0, 200)) - 100;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_sink) begin
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        t_clip got, want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = {res_ch.accepted, res_ch.clipped_start_x, res_ch.clipped_start_y,
                   res_ch.clipped_end_x, res_ch.clipped_end_y};
            if (clip_queue.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = clip_queue.pop_front();
                clips_seen++;
                if (!got.acc) rejects_seen++;
                if (got.acc != want.acc)
                    $display("%0t: accepted exp %b got %b", $time, want.acc, got.acc);
                if (got.sx != want.sx)
                    $display("%0t: start_x exp %0d got %0d", $time, want.sx, got.sx);
                if (got.sy != want.sy)
                    $display("%0t: start_y exp %0d got %0d", $time, want.sy, got.sy);
                if (got.ex != want.ex)
                    $display("%0t: end_x exp %0d got %0d", $time, want.ex, got.ex);
                if (got.ey != want.ey)
                    $display("%0t: end_y exp %0d got %0d", $time, want.ey, got.ey);
                if (got != want) errors++;
            end
        end
    end

    t_row rows[$];

    function automatic t_clip zero_clip();
        return '0;
    endfunction

    function automatic void add_row(t_coord a, t_coord b, t_coord c, t_coord d,
                                    bit known, t_clip want);
        t_row r;
        r.seg = {a, b, c, d};
        r.known = known;
        r.want = want;
        rows.push_back(r);
    endfunction

    initial begin
        t_seg s;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        seg_ch.valid = 0;
        seg_ch.start_x = '0; seg_ch.start_y = '0; seg_ch.end_x = '0; seg_ch.end_y = '0;
        win_xmin = 0; win_ymin = 0; win_xmax = 639; win_ymax = 479;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset window: inside, rejects, and crossings of each edge.
        add_row(10, 10, 600, 400, 1, {1'b1, 16'sd10, 16'sd10, 16'sd600, 16'sd400});
        add_row(0, 0, 639, 479, 1, {1'b1, 16'sd0, 16'sd0, 16'sd639, 16'sd479});
        add_row(-5, 10, -1, 300, 1, zero_clip());
        add_row(700, 10, 800, 300, 1, zero_clip());
        add_row(10, 500, 300, 900, 1, zero_clip());
        add_row(10, -5, 300, -90, 1, zero_clip());
        add_row(-32768, -32768, -32768, 32767, 1, zero_clip());
        add_row(32767, 32767, 32767, 32767, 1, zero_clip());
        add_row(100, 100, 100, 1000, 0, '0);
        add_row(100, 100, 100, -1000, 0, '0);
        add_row(100, 100, 1000, 100, 0, '0);
        add_row(100, 100, -1000, 100, 0, '0);
        add_row(-100, -100, 800, 600, 0, '0);
        add_row(-32768, -32768, 32767, 32767, 0, '0);
        add_row(32767, -32768, -32768, 32767, 0, '0);
        add_row(-50, 240, 700, 240, 0, '0);
        add_row(-10, 470, 20, 700, 0, '0);
        add_row(16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555, 0, '0);
        foreach (rows[i]) send_segment(rows[i].seg, rows[i].known, rows[i].want);

        // Inverted window rejects everything.
        set_window(100, 0, 50, 479);
        send_segment({16'sd70, 16'sd10, 16'sd80, 16'sd20}, 1, zero_clip());
        set_window(0, 200, 639, 100);
        send_segment({16'sd70, 16'sd150, 16'sd80, 16'sd150}, 1, zero_clip());

        // Full-range window and single-point window.
        set_window(-32768, -32768, 32767, 32767);
        send_segment({16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000}, 1,
                     {1'b1, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000});
        set_window(5, 5, 5, 5);
        send_segment({16'sd0, 16'sd0, 16'sd10, 16'sd10}, 0, '0);
        send_segment({16'sd0, 16'sd10, 16'sd10, 16'sd0}, 0, '0);

        // Long receiver stall while segments keep coming.
        set_window(-200, -150, 300, 250);
        hold_sink = 1;
        fork
            begin
                repeat (40 * CLIP_CYCLES) @(posedge i_clk);
                hold_sink = 0;
            end
            for (int i = 0; i < 30; i++) begin
                s = {rand_coord(), rand_coord(), rand_coord(), rand_coord()};
                send_segment(s, 0, '0);
            end
        join

        for (int ph = 0; ph < 6; ph++) begin
            t_coord a, b;
            if (ph == 5) calm = 1;
            if (ph > 0) begin
                a = rand_coord(); b = rand_coord();
                set_window(a < b ? a : b, rand_coord() & 16'sh00FF,
                           a < b ? b : a, 16'sd300 + (rand_coord() & 16'sh03FF));
            end
            for (int i = 0; i < 290; i++) begin
                s = {rand_coord(), rand_coord(), rand_coord(), rand_coord()};
                send_segment(s, 0, '0);
            end
        end
        seg_ch.valid <= 1'b0;

        fork
            while (clip_queue.size() != 0) @(posedge i_clk);
            begin
                repeat (200 * CLIP_CYCLES) @(posedge i_clk);
            end
        join_any
        disable fork;
        repeat (CLIP_CYCLES + 10) @(posedge i_clk);
        if (clip_queue.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, clip_queue.size());
            errors++;
        end
        $display("Clipped %0d segments (%0d rejected) across several windows.",
                 clips_seen, rejects_seen);
        if (errors == 0) begin
            $display("tb_line_window_clipper_core OK");
        end else begin
            $display("tb_line_window_clipper_core NOT OK");
        end
        $finish;
    end

endmodule
